[hw/rtl/char_lcd_bar_graph_glyph_builder_macros.svh]
// Assertion macros for the glyph builder RTL, included by cblg_ser.
`ifndef CHAR_LCD_BAR_GRAPH_GLYPH_BUILDER_MACROS_SVH
`define CHAR_LCD_BAR_GRAPH_GLYPH_BUILDER_MACROS_SVH

// Checks a property on every rising clock edge, ignored while reset is asserted.
`define CBLG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, including during reset.
`define CBLG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cblg_pkg.sv]
// Shared types and constants of the bar-graph glyph builder.
`default_nettype none

package cblg_pkg;

    localparam int MAX_SYMBOLS = 8;
    localparam int NUM_COLS    = 5;
    localparam int NUM_ROWS    = 8;
    localparam int LEVEL_W     = 3;
    localparam int IDX_W       = 3;
    localparam int SLOT_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;
    localparam int DEST_W      = 2;

    localparam int CACHE_W     = NUM_COLS * LEVEL_W;
    localparam int CACHE_IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int ROW_W       = $clog2(NUM_ROWS);

    // Output sequence: command word, one word per glyph row, then the buffer write.
    localparam int LAST_STEP_I = NUM_ROWS + 1;
    localparam int STEP_W      = $clog2(LAST_STEP_I + 1);
    localparam logic [STEP_W-1:0] STEP_CMD  = '0;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LAST_STEP_I);

    localparam logic [BYTE_W-1:0] CGRAM_CMD = 8'h40;
    localparam logic [BYTE_W-1:0] CODE_BASE = 8'h08;

    localparam logic [CFG_IDX_W-1:0] REG_SOLID_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYMBOL = 2'd1;

    typedef enum logic [DEST_W-1:0] {
        DEST_CMD    = 2'd0,
        DEST_DATA   = 2'd1,
        DEST_BUFFER = 2'd2
    } cblg_dest_t;

    typedef logic [NUM_COLS-1:0][LEVEL_W-1:0]  cblg_levels_t;
    typedef logic [NUM_COLS-1:0][NUM_ROWS-1:0] cblg_col_masks_t;
    typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0] cblg_rows_t;

    typedef struct packed {
        logic                changed;
        logic [SLOT_W-1:0]   slot;
        logic [IDX_W-1:0]    idx;
        logic [BYTE_W-1:0]   code;
        cblg_rows_t          rows;
    } cblg_job_t;

endpackage

`default_nettype wire

[hw/rtl/cblg_lane.sv]
// One column lane: turns a column level into the set of lit rows.
`default_nettype none

module cblg_lane (
    input  wire logic [cblg_pkg::LEVEL_W-1:0]  level,
    input  wire logic                          solid,
    output logic      [cblg_pkg::NUM_ROWS-1:0] lit
);
    import cblg_pkg::*;

    logic [ROW_W-1:0] top_row;

    // Level zero sits on the bottom row, row 0 is the top.
    assign top_row = ROW_W'(NUM_ROWS - 1) - ROW_W'(level);

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (solid)
            begin
                lit[r] = (ROW_W'(r) >= top_row);
            end
            else
            begin
                lit[r] = (ROW_W'(r) == top_row);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cblg_merge.sv]
// Merges the lane column masks into glyph rows and detects a level change.
`default_nettype none

module cblg_merge (
    input  wire cblg_pkg::cblg_col_masks_t     col_masks,
    input  wire cblg_pkg::cblg_levels_t        levels,
    input  wire logic [cblg_pkg::CACHE_W-1:0]  cached,
    output cblg_pkg::cblg_rows_t               rows,
    output logic                               changed
);
    import cblg_pkg::*;

    // Column 0 is the leftmost pixel and lands in the top bit of the row.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                rows[r][NUM_COLS-1-c] = col_masks[c][r];
            end
        end
    end

    assign changed = (CACHE_W'(levels) != cached);

endmodule

`default_nettype wire

[hw/rtl/cblg_ser.sv]
// Output sequencer: holds one rendered job; sends one word per cycle while m_tready is high.
`default_nettype none
`include "char_lcd_bar_graph_glyph_builder_macros.svh"

module cblg_ser (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire cblg_pkg::cblg_job_t                 job_in,
    output logic                                     free,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [cblg_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic      [cblg_pkg::DEST_W-1:0]         m_tuser,
    output logic                                     m_tlast
);
    import cblg_pkg::*;

    logic              job_valid_reg;
    logic [STEP_W-1:0] step_reg;
    cblg_job_t         job_reg;
    cblg_dest_t        dest;
    logic [BYTE_W-1:0] byte_value;
    logic [POS_W-1:0]  buffer_position;
    logic [ROW_W-1:0]  row_idx;
    logic              word_taken;

    assign word_taken = job_valid_reg && m_tready;
    assign free       = !job_valid_reg || (m_tready && m_tlast);
    assign row_idx    = ROW_W'(step_reg - STEP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= STEP_CMD;
        end
        else if (load)
        begin
            job_valid_reg <= 1'b1;
            step_reg      <= job_in.changed ? STEP_CMD : LAST_STEP;
        end
        else if (word_taken)
        begin
            if (step_reg == LAST_STEP)
            begin
                job_valid_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_in;
        end
    end

    always_comb
    begin
        case (step_reg)
            STEP_CMD:
            begin
                dest            = DEST_CMD;
                byte_value      = CGRAM_CMD | BYTE_W'({job_reg.slot, 3'b000});
                buffer_position = '0;
            end
            LAST_STEP:
            begin
                dest            = DEST_BUFFER;
                byte_value      = job_reg.code;
                buffer_position = POS_W'(job_reg.idx);
            end
            default:
            begin
                dest            = DEST_DATA;
                byte_value      = BYTE_W'(job_reg.rows[row_idx]);
                buffer_position = '0;
            end
        endcase
    end

    assign m_tvalid = job_valid_reg;
    assign m_tdata  = OUT_DATA_W'({buffer_position, byte_value});
    assign m_tuser  = dest;
    assign m_tlast  = (step_reg == LAST_STEP);

    `CBLG_ASSERT(a_step_range, job_valid_reg |-> (step_reg <= LAST_STEP), "step out of range")
    `CBLG_ASSERT(a_job_holds, (word_taken && !m_tlast) |=> job_valid_reg, "job lost before last word")
    `CBLG_ASSERT(a_cmd_then_row, (word_taken && dest == DEST_CMD) |=> (m_tvalid && m_tuser == DEST_DATA), "command not followed by a row")

endmodule

`default_nettype wire

[hw/rtl/char_lcd_bar_graph_glyph_builder.sv]
// Top level of the character-LCD bar-graph glyph builder.
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | symbol index and five column levels
//  m_      | out | m_tvalid/m_tready  | byte, buffer position, destination, last
//  cfg_    | in  | cfg_we             | solid_mode (index 0), first_symbol (index 1)
//
// An in-range input word whose levels differ from the cached levels of its cell
// yields ten output words (CGRAM address command, eight glyph rows, text-buffer write);
// an unchanged cell yields only the buffer write. The output port moves one word per
// cycle while m_tready is high, which sets the rate.
// Reset clears the level cache, the config registers and all valid flags at once.
// A render stage sits ahead of the output sequencer, so the next input word is taken
// while the previous job still waits on m_tready.
`default_nettype none

module char_lcd_bar_graph_glyph_builder (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // [2:0] symbol_index, [5:3] level_col0, [8:6] level_col1, [11:9] level_col2,
    // [14:12] level_col3, [17:15] level_col4, rest zero
    input  wire logic [cblg_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [7:0] byte_value, [10:8] buffer_position, rest zero
    output logic      [cblg_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] destination
    output logic      [cblg_pkg::DEST_W-1:0]        m_tuser,
    output logic                                    m_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_we,
    input  wire logic [cblg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cblg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cblg_pkg::*;

    logic                    solid_mode_reg;
    logic [SLOT_W-1:0]       first_symbol_reg;
    logic [CACHE_W-1:0]      cache_reg [MAX_SYMBOLS];

    logic                    a_valid_reg;
    logic                    a_valid_next;
    cblg_job_t               a_job_reg;
    cblg_job_t               a_job_next;

    logic [IDX_W-1:0]        idx;
    cblg_levels_t            levels;
    cblg_col_masks_t         col_masks;
    cblg_rows_t              rows;
    logic                    changed;
    logic                    in_range;
    logic [CACHE_IDX_W-1:0]  cache_idx;
    logic                    accept;
    logic                    ser_free;
    logic                    ser_load;

    // Unpack the input word.
    always_comb
    begin
        idx = s_tdata[IDX_W-1:0];
        for (int c = 0; c < NUM_COLS; c++)
        begin
            levels[c] = s_tdata[IDX_W + LEVEL_W*c +: LEVEL_W];
        end
    end

    // Cells beyond the graph are accepted and dropped without touching the cache.
    assign in_range  = ({1'b0, idx} < (IDX_W+1)'(MAX_SYMBOLS));
    assign cache_idx = CACHE_IDX_W'(idx);

    // One lane per pixel column renders that column's lit rows.
    for (genvar c = 0; c < NUM_COLS; c++)
    begin : g_lane
        cblg_lane u_lane (
            .level (levels[c]),
            .solid (solid_mode_reg),
            .lit   (col_masks[c])
        );
    end

    cblg_merge u_merge (
        .col_masks (col_masks),
        .levels    (levels),
        .cached    (cache_reg[cache_idx]),
        .rows      (rows),
        .changed   (changed)
    );

    // The render stage frees up whenever its job moves into the sequencer.
    assign ser_load = a_valid_reg && ser_free;
    assign s_tready = !a_valid_reg || ser_load;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        a_job_next.changed = changed;
        a_job_next.slot    = first_symbol_reg + SLOT_W'(idx);
        a_job_next.idx     = idx;
        a_job_next.code    = CODE_BASE + BYTE_W'(first_symbol_reg) + BYTE_W'(idx);
        a_job_next.rows    = rows;

        if (accept && in_range)
        begin
            a_valid_next = 1'b1;
        end
        else if (ser_load)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            solid_mode_reg   <= 1'b0;
            first_symbol_reg <= '0;
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                cache_reg[i] <= '0;
            end
        end
        else
        begin
            a_valid_reg <= a_valid_next;

            // The cache tracks each accepted in-range cell for later comparisons.
            if (accept && in_range && changed)
            begin
                cache_reg[cache_idx] <= CACHE_W'(levels);
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOLID_MODE:   solid_mode_reg   <= cfg_data[0];
                    REG_FIRST_SYMBOL: first_symbol_reg <= SLOT_W'(cfg_data);
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            a_job_reg <= a_job_next;
        end
    end

    cblg_ser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ser_load),
        .job_in   (a_job_reg),
        .free     (ser_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
